/* design/lie_pkg.sv */
// Shared types, constants and codes for the linear interpolation energy kick block.
package lie_pkg;

  // Field and table geometry
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_SLICES = 1024;
  localparam int ADDR_W     = $clog2(MAX_SLICES);
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 2;

  // Arithmetic widths
  localparam int PROD_W  = 2 * DATA_W + 2;        // 33 x 33 signed product
  localparam int SLOPE_W = PROD_W - FRAC_BITS;    // floored product
  localparam int CAP_W   = DATA_W + 2;            // interpolation term capped at 2^CAP_W
  localparam int LO_W    = 18;                    // low slice of the capped slope
  localparam int HI_W    = CAP_W + 1 - LO_W;      // high slice of the capped slope
  localparam int DM_W    = DATA_W + 1;            // magnitude of time offset
  localparam int PP_W    = DM_W + CAP_W + 1;      // full magnitude product
  localparam int SUM_W   = CAP_W + 3;             // final sum before saturation

  // Start to done latency in clock cycles
  localparam int PIPE_LAT = 9;

  localparam logic [CAP_W:0]      TERM_CAP      = {1'b1, {CAP_W{1'b0}}};
  localparam logic [DATA_W-1:0]   INV_WIDTH_RST = DATA_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]    SLICE_RST     = CNT_W'(2);

  // Item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_KICK = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_COUNT = 2'd0,
    CFG_INV_WIDTH   = 2'd1,
    CFG_ACCEL_KICK  = 2'd2
  } cfg_idx_t;

  // Input word
  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_voltage;
    logic signed [DATA_W-1:0] entry_center;
    logic signed [DATA_W-1:0] particle_time;
    logic signed [DATA_W-1:0] particle_energy;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] new_energy;
    logic                     in_range;
  } out_word_t;

  // Configuration register contents
  typedef struct packed {
    logic [CNT_W-1:0]         slice_count;
    logic [DATA_W-1:0]        inv_width;
    logic signed [DATA_W-1:0] accel_kick;
  } cfg_t;

  // Table write from a load
  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] volt;
    logic signed [DATA_W-1:0] cent;
  } tbl_wr_t;

  // Kick leaving the bin lookup stage
  typedef struct packed {
    logic                     vld;
    logic                     hit;
    logic signed [DATA_W-1:0] ptime;
    logic signed [DATA_W:0]   base;
  } kick_t;

endpackage

/* design/lie_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module lie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* design/lie_cfg.sv */
// Configuration registers and their write port.
module lie_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lie_pkg::DATA_W-1:0]    cfg_data,
  output lie_pkg::cfg_t                 cfg
);
  import lie_pkg::*;

  logic ready;

  assign cfg_ready = ready;

  // Register writes; ready comes up in the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ready           <= 1'b0;
      cfg.slice_count <= SLICE_RST;
      cfg.inv_width   <= INV_WIDTH_RST;
      cfg.accel_kick  <= '0;
    end else begin
      ready <= 1'b1;
      if (cfg_valid && ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SLICE_COUNT: cfg.slice_count <= cfg_data[CNT_W-1:0];
          CFG_INV_WIDTH:   cfg.inv_width   <= cfg_data;
          CFG_ACCEL_KICK:  cfg.accel_kick  <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

endmodule

/* design/lie_front.sv */
// Input stage, table write, bin computation and range check.
module lie_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  lie_pkg::in_word_t            in_word,
  input  lie_pkg::cfg_t                cfg,
  output lie_pkg::tbl_wr_t             wr,
  output logic [lie_pkg::ADDR_W-1:0]   rd_addr0,
  output logic [lie_pkg::ADDR_W-1:0]   rd_addr1,
  output lie_pkg::kick_t               kick
);
  import lie_pkg::*;

  logic                     accept;
  logic                     a_vld;
  in_word_t                 a_word;
  tbl_wr_t                  a_wr;
  tbl_wr_t                  b_wr;
  tbl_wr_t                  c_wr;
  logic signed [DATA_W-1:0] c0;
  logic                     b_vld;
  logic signed [DATA_W:0]   b_diff;
  logic signed [DATA_W-1:0] b_time;
  logic signed [DATA_W:0]   b_base;
  logic                     c_vld;
  logic signed [PROD_W-1:0] c_prod;
  logic signed [DATA_W-1:0] c_time;
  logic signed [DATA_W:0]   c_base;
  logic signed [DATA_W:0]   ivw_s;
  logic [ADDR_W-1:0]        bin;
  logic                     hi_zero;
  logic [CNT_W-1:0]         cnt_eff;
  logic                     hit;

  // Held only through reset and the cycle after
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;
  assign ivw_s  = $signed({1'b0, cfg.inv_width});

  // Stage A: capture the word
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
    if (accept) begin
      a_word <= in_word;
    end
  end

  // Loads write both tables; slot zero centre also kept in a register
  always_comb begin
    a_wr.en   = a_vld && (a_word.op == OP_LOAD) &&
                (32'(a_word.entry_index) < 32'(MAX_SLICES));
    a_wr.addr = ADDR_W'(a_word.entry_index);
    a_wr.volt = a_word.entry_voltage;
    a_wr.cent = a_word.entry_center;
  end

  always_ff @(posedge clk) begin
    if (a_wr.en && (a_wr.addr == '0)) begin
      c0 <= a_word.entry_center;
    end
  end

  // Table write trails the load down to stage C, where kicks read the tables
  always_ff @(posedge clk) begin
    if (rst) begin
      b_wr <= '0;
      c_wr <= '0;
    end else begin
      b_wr <= a_wr;
      c_wr <= b_wr;
    end
  end

  assign wr = c_wr;

  // Stage B: offset from the first centre, energy plus constant kick
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld && (a_word.op == OP_KICK);
    end
    b_diff <= {a_word.particle_time[DATA_W-1], a_word.particle_time} -
              {c0[DATA_W-1], c0};
    b_time <= a_word.particle_time;
    b_base <= {a_word.particle_energy[DATA_W-1], a_word.particle_energy} +
              {cfg.accel_kick[DATA_W-1], cfg.accel_kick};
  end

  // Stage C: scaled offset, bin is its floor
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_prod <= b_diff * ivw_s;
    c_time <= b_time;
    c_base <= b_base;
  end

  // Range check against the slices in use
  always_comb begin
    hi_zero  = (c_prod[PROD_W-1:FRAC_BITS+ADDR_W] == '0);
    bin      = c_prod[FRAC_BITS+ADDR_W-1:FRAC_BITS];
    cnt_eff  = (32'(cfg.slice_count) > 32'(MAX_SLICES)) ? CNT_W'(MAX_SLICES)
                                                        : cfg.slice_count;
    hit      = (cnt_eff >= CNT_W'(2)) && hi_zero &&
               (CNT_W'(bin) < (cnt_eff - CNT_W'(1)));
    rd_addr0 = bin;
    rd_addr1 = bin + ADDR_W'(1);
  end

  assign kick.vld   = c_vld;
  assign kick.hit   = hit;
  assign kick.ptime = c_time;
  assign kick.base  = c_base;

endmodule

/* design/lie_back.sv */
// Slope, interpolation term with cap, final sum and saturation.
module lie_back (
  input  logic                           clk,
  input  logic                           rst,
  input  lie_pkg::kick_t                 kick,
  input  logic signed [lie_pkg::DATA_W-1:0] v0,
  input  logic signed [lie_pkg::DATA_W-1:0] v1,
  input  logic signed [lie_pkg::DATA_W-1:0] cb,
  input  lie_pkg::cfg_t                  cfg,
  output logic                           done,
  output lie_pkg::out_word_t             out_word
);
  import lie_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN =
    {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic                      d_vld;
  logic                      d_hit;
  logic signed [DATA_W-1:0]  d_time;
  logic signed [DATA_W:0]    d_base;
  logic                      e_vld;
  logic                      e_hit;
  logic signed [DATA_W:0]    e_dv;
  logic signed [DATA_W:0]    e_dt;
  logic signed [DATA_W+1:0]  e_base;
  logic                      f_vld;
  logic                      f_hit;
  logic signed [PROD_W-1:0]  f_prod;
  logic signed [DATA_W:0]    f_dt;
  logic signed [DATA_W+1:0]  f_base;
  logic                      g_vld;
  logic                      g_hit;
  logic                      g_neg;
  logic [DM_W+LO_W-1:0]      g_pl;
  logic [DM_W+HI_W-1:0]      g_ph;
  logic signed [DATA_W+1:0]  g_base;
  logic                      h_vld;
  logic                      h_hit;
  logic signed [CAP_W+1:0]   h_term;
  logic signed [DATA_W+1:0]  h_base;
  logic signed [DATA_W:0]    ivw_s;
  logic signed [SLOPE_W-1:0] slope;
  logic [SLOPE_W-1:0]        sm;
  logic [CAP_W:0]            sm_c;
  logic [DM_W-1:0]           dm;
  logic                      neg;
  logic [PP_W-1:0]           p;
  logic [CAP_W:0]            pc;
  logic signed [CAP_W+1:0]   term_mag;
  logic signed [CAP_W+1:0]   term;
  logic signed [SUM_W-1:0]   sum;

  assign ivw_s = $signed({1'b0, cfg.inv_width});

  // Stage D: table data arrives alongside the kick
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= kick.vld;
    end
    d_hit  <= kick.hit;
    d_time <= kick.ptime;
    d_base <= kick.base;
  end

  // Stage E: voltage step, time from bin centre, base plus v0 when in range
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_hit  <= d_hit;
    e_dv   <= {v1[DATA_W-1], v1} - {v0[DATA_W-1], v0};
    e_dt   <= {d_time[DATA_W-1], d_time} - {cb[DATA_W-1], cb};
    e_base <= d_hit ? ({d_base[DATA_W], d_base} + {{2{v0[DATA_W-1]}}, v0})
                    : {d_base[DATA_W], d_base};
  end

  // Stage F: slope product
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
    f_hit  <= e_hit;
    f_prod <= e_dv * ivw_s;
    f_dt   <= e_dt;
    f_base <= e_base;
  end

  // Magnitudes; a slope past the cap is clamped to it, so any nonzero offset gives a capped term
  always_comb begin
    slope = f_prod[PROD_W-1:FRAC_BITS];
    sm    = slope[SLOPE_W-1] ? SLOPE_W'(-slope) : SLOPE_W'(slope);
    sm_c  = (sm >= SLOPE_W'(TERM_CAP)) ? TERM_CAP : sm[CAP_W:0];
    dm    = f_dt[DATA_W] ? DM_W'(-f_dt) : DM_W'(f_dt);
    neg   = slope[SLOPE_W-1] ^ f_dt[DATA_W];
  end

  // Stage G: two partial products of offset times capped slope
  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= f_vld;
    end
    g_hit  <= f_hit;
    g_neg  <= neg;
    g_pl   <= dm * sm_c[LO_W-1:0];
    g_ph   <= dm * sm_c[CAP_W:LO_W];
    g_base <= f_base;
  end

  // Combine, cap and sign the term; zero when out of range
  always_comb begin
    p        = PP_W'(g_pl) + (PP_W'(g_ph) << LO_W);
    pc       = (p >= PP_W'(TERM_CAP)) ? TERM_CAP : p[CAP_W:0];
    term_mag = $signed({1'b0, pc});
    if (!g_hit) begin
      term = '0;
    end else if (g_neg) begin
      term = -term_mag;
    end else begin
      term = term_mag;
    end
  end

  // Stage H
  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= g_vld;
    end
    h_hit  <= g_hit;
    h_term <= term;
    h_base <= g_base;
  end

  assign sum = SUM_W'(h_base) + SUM_W'(h_term);

  // Output register with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_vld;
    end
    out_word.in_range <= h_hit;
    if (sum > SUM_MAX) begin
      out_word.new_energy <= SUM_MAX[DATA_W-1:0];
    end else if (sum < SUM_MIN) begin
      out_word.new_energy <= SUM_MIN[DATA_W-1:0];
    end else begin
      out_word.new_energy <= sum[DATA_W-1:0];
    end
  end

endmodule

/* design/linear_interp_energy_kick_core.sv */
// Top level of the linear interpolation energy kick block.
// One word per clock: start is taken whenever busy is low, and busy is high
// only during reset and for the cycle after it. A kick word gives its result
// on out_word with done high for exactly one cycle, at the end of a
// nine-register pipeline (input, offset, bin multiply, table read,
// differences, slope multiply, split partial products, term cap, saturating
// output). Results follow the order of the kicks and must be taken in the
// cycle done is high; there is no hold-off. A load word writes one
// voltage/centre slot once its write has passed down to stage C, in step
// with the table reads of the kicks around it, and gives no result; a kick
// that follows it sees the new entry and a kick ahead of it does not. Table
// slots read before they are written give undefined energies. Configuration
// writes are taken on cfg_valid and cfg_ready and are only allowed while no
// kick is in flight.
module linear_interp_energy_kick_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lie_pkg::in_word_t             in_word,
  output logic                          done,
  output lie_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lie_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lie_pkg::DATA_W-1:0]    cfg_data
);
  import lie_pkg::*;

  cfg_t              cfg;
  tbl_wr_t           wr;
  kick_t             kick;
  logic [ADDR_W-1:0] rd_addr0;
  logic [ADDR_W-1:0] rd_addr1;
  logic [DATA_W-1:0] v0_raw;
  logic [DATA_W-1:0] v1_raw;
  logic [DATA_W-1:0] cb_raw;

  lie_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lie_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .cfg      (cfg),
    .wr       (wr),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .kick     (kick)
  );

  // Voltage table kept twice for the two reads per kick
  lie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SLICES)) u_volt_lo (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.volt),
    .raddr (rd_addr0),
    .rdata (v0_raw)
  );

  lie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SLICES)) u_volt_hi (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.volt),
    .raddr (rd_addr1),
    .rdata (v1_raw)
  );

  lie_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SLICES)) u_cent (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.cent),
    .raddr (rd_addr0),
    .rdata (cb_raw)
  );

  lie_back u_back (
    .clk      (clk),
    .rst      (rst),
    .kick     (kick),
    .v0       ($signed(v0_raw)),
    .v1       ($signed(v1_raw)),
    .cb       ($signed(cb_raw)),
    .cfg      (cfg),
    .done     (done),
    .out_word (out_word)
  );

endmodule

/* design/lie_checker.sv */
// Port-level checks for the energy kick core and their bind.
module lie_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input lie_pkg::in_word_t             in_word,
  input logic                          done,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);
  import lie_pkg::*;

  logic kick_acc;

  assign kick_acc = start && !busy && !rst && (in_word.op == OP_KICK);

  // Every kick, and only a kick, gives one result a fixed time later
  a_kick_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(kick_acc, PIPE_LAT))
    else $error("done does not match a kick accepted PIPE_LAT cycles before");

  // No stall once out of reset
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !busy)
    else $error("busy high after reset");

  // Config port always open once out of reset
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> cfg_ready)
    else $error("cfg_ready low after reset");

endmodule

bind linear_interp_energy_kick_core lie_checker u_lie_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .done      (done),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
